// ===== rtl/pft_pkg.sv =====
package pft_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_STAGES        = 32;

  localparam int POS_W     = 32;
  localparam int ANG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int ROT_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_EGO_X_POS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EGO_Y_POS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EGO_HEADING = 2'd2;

  localparam logic [ANG_W-1:0]        QUARTER_TURN = 16'd16384;
  localparam logic signed [ROT_W-1:0] CORDIC_START = 32'sd652032874;
  localparam logic signed [ROT_W-1:0] ONE_Q30      = 32'sd1073741824;

  typedef struct packed {
    logic signed [POS_W:0]   px;
    logic signed [POS_W:0]   py;
    logic signed [POS_W-1:0] vx;
    logic signed [POS_W-1:0] vy;
    logic signed [POS_W-1:0] offx;
    logic signed [POS_W-1:0] offy;
    logic [ANG_W-1:0]        ohd;
  } item_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] z;
    logic [1:0]              quad;
    logic                    exact;
    item_t                   item;
  } cell_t;

  // Arctangent of 2^-i as a fraction of a quarter turn scaled to 2^30.
  function automatic logic signed [ROT_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ROT_W-1:0] r;
    case (idx)
      5'd0:  r = 32'sd536870912;
      5'd1:  r = 32'sd316933406;
      5'd2:  r = 32'sd167458907;
      5'd3:  r = 32'sd85004756;
      5'd4:  r = 32'sd42667331;
      5'd5:  r = 32'sd21354465;
      5'd6:  r = 32'sd10680862;
      5'd7:  r = 32'sd5340245;
      5'd8:  r = 32'sd2670163;
      5'd9:  r = 32'sd1335087;
      5'd10: r = 32'sd667544;
      5'd11: r = 32'sd333772;
      5'd12: r = 32'sd166886;
      5'd13: r = 32'sd83443;
      5'd14: r = 32'sd41722;
      5'd15: r = 32'sd20861;
      5'd16: r = 32'sd10430;
      5'd17: r = 32'sd5215;
      5'd18: r = 32'sd2608;
      5'd19: r = 32'sd1304;
      5'd20: r = 32'sd652;
      5'd21: r = 32'sd326;
      5'd22: r = 32'sd163;
      5'd23: r = 32'sd81;
      5'd24: r = 32'sd41;
      5'd25: r = 32'sd20;
      5'd26: r = 32'sd10;
      5'd27: r = 32'sd5;
      5'd28: r = 32'sd3;
      5'd29: r = 32'sd1;
      5'd30: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/pft_in_if.sv =====
interface pft_in_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic signed [pft_pkg::POS_W-1:0]  pos_x;
  logic signed [pft_pkg::POS_W-1:0]  pos_y;
  logic        [pft_pkg::ANG_W-1:0]  heading;
  logic signed [pft_pkg::POS_W-1:0]  vel_x;
  logic signed [pft_pkg::POS_W-1:0]  vel_y;

  modport source (output valid, action, pos_x, pos_y, heading, vel_x, vel_y, input ready);
  modport sink   (input valid, action, pos_x, pos_y, heading, vel_x, vel_y, output ready);
endinterface

// ===== rtl/pft_out_if.sv =====
interface pft_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pft_pkg::POS_W-1:0]  out_x;
  logic signed [pft_pkg::POS_W-1:0]  out_y;
  logic        [pft_pkg::ANG_W-1:0]  out_heading;
  logic signed [pft_pkg::POS_W-1:0]  out_vel_x;
  logic signed [pft_pkg::POS_W-1:0]  out_vel_y;

  modport source (output valid, out_x, out_y, out_heading, out_vel_x, out_vel_y,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_heading, out_vel_x, out_vel_y,
                  output ready);
endinterface

// ===== rtl/pft_cordic_cell.sv =====
module pft_cordic_cell #(
  parameter int STAGE_IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  pft_pkg::cell_t  data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output pft_pkg::cell_t  data_o
);

  logic                            valid_q;
  pft_pkg::cell_t                  data_q, data_d;
  logic signed [pft_pkg::ROT_W-1:0] dx, dy, ang;

  assign ready_o = !valid_q || ready_i;
  assign dx  = data_i.y >>> STAGE_IDX;
  assign dy  = data_i.x >>> STAGE_IDX;
  assign ang = pft_pkg::atan_q30(STAGE_IDX[4:0]);

  // Rotate toward a zero residual angle by one micro-rotation.
  always_comb begin
    data_d = data_i;
    if (!data_i.z[pft_pkg::ROT_W-1]) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - ang;
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/pft_rot_lane.sv =====
module pft_rot_lane (
  input  logic                              clk_i,
  input  logic                              en_m_i,
  input  logic                              en_f_i,
  input  logic signed [pft_pkg::POS_W:0]    a_i,
  input  logic signed [pft_pkg::ROT_W-1:0]  k0_i,
  input  logic signed [pft_pkg::POS_W:0]    b_i,
  input  logic signed [pft_pkg::ROT_W-1:0]  k1_i,
  input  logic signed [pft_pkg::POS_W-1:0]  off_i,
  output logic signed [pft_pkg::POS_W-1:0]  res_o
);

  localparam int PW = pft_pkg::POS_W + 1 + pft_pkg::ROT_W;
  localparam int SW = PW + 1;
  localparam int TW = pft_pkg::POS_W + 5;

  logic signed [PW-1:0]             p0_q, p1_q;
  logic signed [pft_pkg::POS_W-1:0] off_q;
  logic signed [SW-1:0]             sum, rnd, shf;
  logic signed [TW-1:0]             tot;
  logic signed [pft_pkg::POS_W-1:0] res_d, res_q;

  // Round half up from Q.30, add the offset, then clamp to 32 bits.
  always_comb begin
    sum = SW'(p0_q) + SW'(p1_q);
    rnd = sum + (SW'(1) <<< 29);
    shf = rnd >>> 30;
    tot = shf[TW-1:0] + TW'(off_q);
    if (tot[TW-1:pft_pkg::POS_W-1] == '0 || tot[TW-1:pft_pkg::POS_W-1] == '1) begin
      res_d = tot[pft_pkg::POS_W-1:0];
    end else if (tot[TW-1]) begin
      res_d = {1'b1, {(pft_pkg::POS_W-1){1'b0}}};
    end else begin
      res_d = {1'b0, {(pft_pkg::POS_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_m_i) begin
      p0_q  <= a_i * k0_i;
      p1_q  <= b_i * k1_i;
      off_q <= off_i;
    end
    if (en_f_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/pose_frame_transform_2d_top.sv =====
// Rigid 2-D frame transform of one obstacle word (position, heading, velocity) between
// the vehicle frame and the world east-north frame, chosen per word by the action bit.
// The rotation angle comes from the ego heading register, and its cosine and sine are
// produced per word by a chain of CORDIC cells, one micro-rotation per cell. A word
// passes an input register, CORDIC_STAGES cells (capped at MAX_STAGES), a multiply
// stage with eight 33x32 multipliers and a round/offset/saturate stage that doubles
// as the output register. The chain accepts a new word in every cycle unless a stall
// has filled its stages back to the input; each stage holds its word only while the
// stage after it is full and stalled, so a waiting result does not keep upstream
// stages from filling. Write the ego registers only while no word is in flight.

module pose_frame_transform_2d_top #(
  parameter int CORDIC_STAGES = pft_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pft_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pft_pkg::CFG_W-1:0]        cfg_data_i,
  pft_in_if.sink                           in_i,
  pft_out_if.source                        out_o
);

  // Only 32 micro-rotations are meaningful at Q1.30.
  localparam int NSTG = (CORDIC_STAGES < pft_pkg::MAX_STAGES) ? CORDIC_STAGES
                                                             : pft_pkg::MAX_STAGES;
  localparam int PW = pft_pkg::POS_W;
  localparam int RW = pft_pkg::ROT_W;

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  // Ego registers.
  logic signed [PW-1:0]            ego_x_q, ego_y_q;
  logic [pft_pkg::ANG_W-1:0]       ego_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ego_x_q <= '0;
      ego_y_q <= '0;
      ego_h_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pft_pkg::REG_EGO_X_POS:   ego_x_q <= cfg_data_i[PW-1:0];
        pft_pkg::REG_EGO_Y_POS:   ego_y_q <= cfg_data_i[PW-1:0];
        pft_pkg::REG_EGO_HEADING: ego_h_q <= cfg_data_i[pft_pkg::ANG_W-1:0];
        default: ;
      endcase
    end
  end

  // Chain of stage valids, data and readies. Entry 0 is the input register.
  logic           chain_v   [NSTG+1];
  logic           chain_rdy [NSTG+1];
  pft_pkg::cell_t chain_d   [NSTG+1];

  logic           v_m_q, v_f_q, rdy_m, rdy_f, rdy_p;
  logic           v_p_q;
  pft_pkg::cell_t prep_d, prep_q;

  assign rdy_f      = !v_f_q || out_o.ready;
  assign rdy_m      = !v_m_q || rdy_f;
  assign rdy_p      = !v_p_q || chain_rdy[0];
  assign in_i.ready = rdy_p;

  // Input stage: pick the rotation angle, shift the heading and move the
  // position to the ego origin when going to the vehicle frame.
  logic [pft_pkg::ANG_W-1:0] ang;
  always_comb begin
    prep_d = '0;
    if (in_i.action) begin
      ang             = pft_pkg::QUARTER_TURN - ego_h_q;
      prep_d.item.ohd = in_i.heading - ego_h_q + pft_pkg::QUARTER_TURN;
      prep_d.item.px  = {in_i.pos_x[PW-1], in_i.pos_x} - {ego_x_q[PW-1], ego_x_q};
      prep_d.item.py  = {in_i.pos_y[PW-1], in_i.pos_y} - {ego_y_q[PW-1], ego_y_q};
      prep_d.item.offx = '0;
      prep_d.item.offy = '0;
    end else begin
      ang             = ego_h_q - pft_pkg::QUARTER_TURN;
      prep_d.item.ohd = in_i.heading + ego_h_q - pft_pkg::QUARTER_TURN;
      prep_d.item.px  = {in_i.pos_x[PW-1], in_i.pos_x};
      prep_d.item.py  = {in_i.pos_y[PW-1], in_i.pos_y};
      prep_d.item.offx = ego_x_q;
      prep_d.item.offy = ego_y_q;
    end
    prep_d.item.vx = in_i.vel_x;
    prep_d.item.vy = in_i.vel_y;
    // The two top angle bits pick the quadrant; the rest is the residual
    // angle on a 2^32 full-turn scale.
    prep_d.quad  = ang[pft_pkg::ANG_W-1 -: 2];
    prep_d.z     = {2'b00, ang[pft_pkg::ANG_W-3:0], {(RW - pft_pkg::ANG_W){1'b0}}};
    prep_d.exact = (ang[pft_pkg::ANG_W-3:0] == '0);
    prep_d.x     = pft_pkg::CORDIC_START;
    prep_d.y     = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_p_q <= 1'b0;
    end else if (rdy_p) begin
      v_p_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_p) begin
      prep_q <= prep_d;
    end
  end

  assign chain_v[0] = v_p_q;
  assign chain_d[0] = prep_q;
  assign chain_rdy[NSTG] = rdy_m;

  for (genvar k = 0; k < NSTG; k++) begin : g_cell
    pft_cordic_cell #(
      .STAGE_IDX (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_v[k]),
      .ready_o (chain_rdy[k]),
      .data_i  (chain_d[k]),
      .valid_o (chain_v[k+1]),
      .ready_i (chain_rdy[k+1]),
      .data_o  (chain_d[k+1])
    );
  end

  // Quadrant fold-out of the chain result. An exact quadrant angle ignores the
  // micro-rotation result and uses the unit vector as is.
  pft_pkg::cell_t          last;
  logic signed [RW-1:0]    bx, by, cos_v, sin_v, nsin_v;

  assign last = chain_d[NSTG];

  always_comb begin
    bx = last.exact ? pft_pkg::ONE_Q30 : last.x;
    by = last.exact ? '0 : last.y;
    case (last.quad)
      QUAD_I:   begin cos_v = bx;  sin_v = by;  end
      QUAD_II:  begin cos_v = -by; sin_v = bx;  end
      QUAD_III: begin cos_v = -bx; sin_v = -by; end
      QUAD_IV:  begin cos_v = by;  sin_v = -bx; end
      default:  begin cos_v = bx;  sin_v = by;  end
    endcase
    nsin_v = -sin_v;
  end

  // Multiply and finish stages.
  logic [pft_pkg::ANG_W-1:0] ohd_m_q, ohd_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_m_q <= 1'b0;
      v_f_q <= 1'b0;
    end else begin
      if (rdy_m) begin
        v_m_q <= chain_v[NSTG];
      end
      if (rdy_f) begin
        v_f_q <= v_m_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_m) begin
      ohd_m_q <= last.item.ohd;
    end
    if (rdy_f) begin
      ohd_f_q <= ohd_m_q;
    end
  end

  logic signed [PW:0] vx_ext, vy_ext;
  assign vx_ext = {last.item.vx[PW-1], last.item.vx};
  assign vy_ext = {last.item.vy[PW-1], last.item.vy};

  logic signed [PW-1:0] rx, ry, rvx, rvy;

  pft_rot_lane u_lane_x (
    .clk_i (clk_i), .en_m_i (rdy_m), .en_f_i (rdy_f),
    .a_i (last.item.px), .k0_i (cos_v), .b_i (last.item.py), .k1_i (nsin_v),
    .off_i (last.item.offx), .res_o (rx)
  );

  pft_rot_lane u_lane_y (
    .clk_i (clk_i), .en_m_i (rdy_m), .en_f_i (rdy_f),
    .a_i (last.item.px), .k0_i (sin_v), .b_i (last.item.py), .k1_i (cos_v),
    .off_i (last.item.offy), .res_o (ry)
  );

  pft_rot_lane u_lane_vx (
    .clk_i (clk_i), .en_m_i (rdy_m), .en_f_i (rdy_f),
    .a_i (vx_ext), .k0_i (cos_v), .b_i (vy_ext), .k1_i (nsin_v),
    .off_i ('0), .res_o (rvx)
  );

  pft_rot_lane u_lane_vy (
    .clk_i (clk_i), .en_m_i (rdy_m), .en_f_i (rdy_f),
    .a_i (vx_ext), .k0_i (sin_v), .b_i (vy_ext), .k1_i (cos_v),
    .off_i ('0), .res_o (rvy)
  );

  assign out_o.valid       = v_f_q;
  assign out_o.out_x       = rx;
  assign out_o.out_y       = ry;
  assign out_o.out_heading = ohd_f_q;
  assign out_o.out_vel_x   = rvx;
  assign out_o.out_vel_y   = rvy;

endmodule

// ===== rtl/pft_checker.sv =====
module pft_checker #(
  parameter int STAGES = pft_pkg::CORDIC_STAGES_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic signed [pft_pkg::POS_W-1:0] out_x_i,
  input logic signed [pft_pkg::POS_W-1:0] out_y_i,
  input logic        [pft_pkg::ANG_W-1:0] out_heading_i,
  input logic signed [pft_pkg::POS_W-1:0] out_vel_x_i,
  input logic signed [pft_pkg::POS_W-1:0] out_vel_y_i
);

  localparam int NSTG  = (STAGES < pft_pkg::MAX_STAGES) ? STAGES : pft_pkg::MAX_STAGES;
  localparam int DEPTH = NSTG + 3;
  localparam int CW    = $clog2(DEPTH + 2);

  logic [CW-1:0] pend_q, pend_d;
  logic          acc, del;

  assign acc = in_valid_i && in_ready_i;
  assign del = out_valid_i && out_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (acc && !del) begin
      pend_d = pend_q + CW'(1);
    end else if (del && !acc) begin
      pend_d = pend_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // With the output side taking words, every stage is free to move.
  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while output is ready");

  // A result can only come from a word accepted earlier.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pend_q != '0))
    else $error("result without a pending word");

  // The pipeline never holds more words than it has stages.
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= CW'(DEPTH))
    else $error("more words in flight than pipeline stages");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_x_i) &&
      $stable(out_y_i) && $stable(out_heading_i) && $stable(out_vel_x_i) &&
      $stable(out_vel_y_i)))
    else $error("stalled result changed");

endmodule

bind pose_frame_transform_2d_top pft_checker #(
  .STAGES (CORDIC_STAGES)
) u_pft_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_x_i       (out_o.out_x),
  .out_y_i       (out_o.out_y),
  .out_heading_i (out_o.out_heading),
  .out_vel_x_i   (out_o.out_vel_x),
  .out_vel_y_i   (out_o.out_vel_y)
);

// ===== tb/tb_pose_frame_transform_2d_top.sv =====
module tb_pose_frame_transform_2d_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_W     = pft_pkg::POS_W;
  localparam int ANG_W     = pft_pkg::ANG_W;
  localparam int CFG_IDX_W = pft_pkg::CFG_IDX_W;
  localparam int CFG_W     = pft_pkg::CFG_W;

  // The action bit picks the direction of the transform for each obstacle word.
  localparam logic TO_WORLD   = 1'b0;
  localparam logic TO_VEHICLE = 1'b1;

  // Index 3 does not name a register, so a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  localparam logic signed [POS_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] Q_MIN = 32'sh8000_0000;

  localparam longint SAT_HI   = 64'sd2147483647;
  localparam longint SAT_LO   = -64'sd2147483648;
  localparam longint HALF_LSB = 64'sd536870912;

  // The pipeline is CORDIC_STAGES + 3 deep; the rest is margin.
  localparam int          SETTLE_CYCLES = pft_pkg::CORDIC_STAGES_DEF + 12;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          RAND_PHASES   = 8;
  localparam int          WORDS_PER_PHASE = 56;

  // Micro-rotation angles atan(2^-i), a quarter turn being 2^30.
  localparam longint ARCTAN_STEP [0:31] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1, 1, 0
  };

  typedef struct packed {
    logic                    action;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [ANG_W-1:0]        heading;
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
  } obstacle_t;

  typedef struct packed {
    logic signed [POS_W-1:0] out_x;
    logic signed [POS_W-1:0] out_y;
    logic [ANG_W-1:0]        out_heading;
    logic signed [POS_W-1:0] out_vel_x;
    logic signed [POS_W-1:0] out_vel_y;
  } pose_t;

  // The board keeps its own copy of the ego registers, turns every accepted
  // obstacle into the pose the block should produce, and holds those poses in
  // order until the block delivers them.
  class frame_xform_board;
    logic signed [POS_W-1:0] ego_x;
    logic signed [POS_W-1:0] ego_y;
    logic [ANG_W-1:0]        ego_hd;
    pose_t                   pending_poses[$];
    int unsigned             mismatches;

    function new();
      ego_x      = '0;
      ego_y      = '0;
      ego_hd     = '0;
      mismatches = 0;
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        pft_pkg::REG_EGO_X_POS:   ego_x = data;
        pft_pkg::REG_EGO_Y_POS:   ego_y = data;
        pft_pkg::REG_EGO_HEADING: ego_hd = data[ANG_W-1:0];
        default: ;
      endcase
    endfunction

    // Cosine and sine in Q1.30 from a rotation-mode CORDIC on the residual
    // angle; the two top bits of the widened angle pick the quadrant.
    function void sin_cos(logic [ANG_W-1:0] ang, output longint c, output longint s);
      logic [31:0] a;
      longint x, y, z, dx, dy;
      a = {ang, 16'h0000};
      z = longint'({2'b00, a[29:0]});
      x = longint'(pft_pkg::CORDIC_START);
      y = 0;
      if (z == 0) begin
        x = longint'(pft_pkg::ONE_Q30);
      end else begin
        for (int i = 0; i < pft_pkg::CORDIC_STAGES_DEF && i < pft_pkg::MAX_STAGES; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ARCTAN_STEP[i];
          end else begin
            x = x + dx;
            y = y - dy;
            z = z + ARCTAN_STEP[i];
          end
        end
      end
      case (a[31:30])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function longint round_sat(longint acc, longint off);
      longint v;
      v = ((acc + HALF_LSB) >>> 30) + off;
      if (v > SAT_HI) v = SAT_HI;
      else if (v < SAT_LO) v = SAT_LO;
      return v;
    endfunction

    function pose_t transform_pose(obstacle_t o);
      longint px, py, vx, vy, offx, offy, c, s;
      logic [ANG_W-1:0] ang, ohd;
      pose_t r;
      px = longint'($signed(o.pos_x));
      py = longint'($signed(o.pos_y));
      vx = longint'($signed(o.vel_x));
      vy = longint'($signed(o.vel_y));
      if (o.action == TO_VEHICLE) begin
        ang  = pft_pkg::QUARTER_TURN - ego_hd;
        ohd  = o.heading - ego_hd + pft_pkg::QUARTER_TURN;
        px   = px - longint'(ego_x);
        py   = py - longint'(ego_y);
        offx = 0;
        offy = 0;
      end else begin
        ang  = ego_hd - pft_pkg::QUARTER_TURN;
        ohd  = o.heading + ego_hd - pft_pkg::QUARTER_TURN;
        offx = longint'(ego_x);
        offy = longint'(ego_y);
      end
      sin_cos(ang, c, s);
      r.out_x       = POS_W'(round_sat(px * c - py * s, offx));
      r.out_y       = POS_W'(round_sat(px * s + py * c, offy));
      r.out_heading = ohd;
      r.out_vel_x   = POS_W'(round_sat(vx * c - vy * s, 0));
      r.out_vel_y   = POS_W'(round_sat(vx * s + vy * c, 0));
      return r;
    endfunction

    function void note_obstacle(obstacle_t o);
      pending_poses.push_back(transform_pose(o));
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_pose(pose_t got);
      pose_t want;
      if (pending_poses.size() == 0) begin
        report($sformatf("pose word with none pending, x=%0d y=%0d", got.out_x, got.out_y));
        return;
      end
      want = pending_poses.pop_front();
      if (got.out_x !== want.out_x)
        report($sformatf("out_x got %0d expected %0d", got.out_x, want.out_x));
      if (got.out_y !== want.out_y)
        report($sformatf("out_y got %0d expected %0d", got.out_y, want.out_y));
      if (got.out_heading !== want.out_heading)
        report($sformatf("out_heading got %0d expected %0d",
                         got.out_heading, want.out_heading));
      if (got.out_vel_x !== want.out_vel_x)
        report($sformatf("out_vel_x got %0d expected %0d", got.out_vel_x, want.out_vel_x));
      if (got.out_vel_y !== want.out_vel_y)
        report($sformatf("out_vel_y got %0d expected %0d", got.out_vel_y, want.out_vel_y));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  pft_in_if  in_if ();
  pft_out_if out_if ();

  frame_xform_board board = new();

  // When set, the sender puts words back to back and the receiver never stalls.
  bit tx_calm;
  bit rx_calm;

  pose_frame_transform_2d_top #(
    .CORDIC_STAGES(pft_pkg::CORDIC_STAGES_DEF)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Idle stretches are mostly short, now and then longer, and rarely long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic int pick_gap();
    if (tx_calm) return 0;
    if ($urandom_range(0, 99) < 60) return 0;
    return idle_len();
  endfunction

  // Coordinates are mostly small, so offsets and rotations stay visible, with
  // full-range values and the extremes mixed in to reach saturation.
  function automatic logic signed [POS_W-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        case ($urandom_range(0, 3))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return $urandom;
      default: return int'($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
    endcase
  endfunction

  function automatic logic [ANG_W-1:0] rand_angle();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return ANG_W'(pft_pkg::QUARTER_TURN * $urandom_range(0, 3));
    if (r == 2) begin
      return ANG_W'(pft_pkg::QUARTER_TURN * $urandom_range(0, 3) +
                    $urandom_range(0, 2) - 1);
    end
    return ANG_W'($urandom);
  endfunction

  function automatic obstacle_t make_obstacle(logic act, logic signed [POS_W-1:0] px,
                                              logic signed [POS_W-1:0] py,
                                              logic [ANG_W-1:0] hd,
                                              logic signed [POS_W-1:0] vx,
                                              logic signed [POS_W-1:0] vy);
    obstacle_t o;
    o.action  = act;
    o.pos_x   = px;
    o.pos_y   = py;
    o.heading = hd;
    o.vel_x   = vx;
    o.vel_y   = vy;
    return o;
  endfunction

  function automatic obstacle_t rand_obstacle();
    return make_obstacle(1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                         rand_angle(), rand_coord(), rand_coord());
  endfunction

  task automatic put_payload(obstacle_t o);
    in_if.action  <= o.action;
    in_if.pos_x   <= o.pos_x;
    in_if.pos_y   <= o.pos_y;
    in_if.heading <= o.heading;
    in_if.vel_x   <= o.vel_x;
    in_if.vel_y   <= o.vel_y;
  endtask

  // Offers one obstacle word and returns at the edge that accepts it. With no gap,
  // valid simply stays high from the previous word, so it is never dropped and
  // raised in the same step. During a gap the payload carries junk.
  task automatic send_obstacle(obstacle_t o);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) begin
        put_payload(rand_obstacle());
        @(posedge clk_i);
      end
    end
    in_if.valid <= 1'b1;
    put_payload(o);
    do @(posedge clk_i); while (!in_if.ready);
    board.note_obstacle(o);
  endtask

  // Stops offering words, waits for every pending pose to come out, then lets the
  // pipeline settle so that no word is in flight.
  task automatic drain_pipe();
    in_if.valid <= 1'b0;
    while (board.pending_poses.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.load_reg(idx, data);
  endtask

  // Loads all three ego registers while the block is idle. The heading write
  // carries random upper bits, which the register must drop. A write to the
  // unused index may follow and must leave every register alone.
  task automatic set_ego(logic signed [POS_W-1:0] ex, logic signed [POS_W-1:0] ey,
                         logic [ANG_W-1:0] eh, bit junk);
    drain_pipe();
    write_reg(pft_pkg::REG_EGO_X_POS, ex);
    write_reg(pft_pkg::REG_EGO_Y_POS, ey);
    write_reg(pft_pkg::REG_EGO_HEADING, {16'($urandom), eh});
    if (junk) write_reg(REG_NONE, $urandom);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result side: checks every accepted pose word and plays random back-pressure.
  initial begin : pose_sink
    int   stall;
    pose_t got;
    stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got.out_x       = out_if.out_x;
        got.out_y       = out_if.out_y;
        got.out_heading = out_if.out_heading;
        got.out_vel_x   = out_if.out_vel_x;
        got.out_vel_y   = out_if.out_vel_y;
        board.check_pose(got);
      end
      if (stall == 0 && !rx_calm && $urandom_range(0, 99) < 25) stall = idle_len();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // A hung handshake must not hang the run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    obstacle_t directed[$];
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= pft_pkg::REG_EGO_X_POS;
    cfg_data_i   <= '0;
    in_if.valid  <= 1'b0;
    put_payload(make_obstacle(TO_WORLD, '0, '0, '0, '0, '0));
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset registers: the ego heading is zero, so both directions rotate by an
    // exact quarter turn. Swapping the axes of the most negative value overflows,
    // which must saturate.
    directed.push_back(make_obstacle(TO_WORLD, '0, '0, '0, '0, '0));
    directed.push_back(make_obstacle(TO_WORLD, Q_MAX, Q_MAX, 16'hFFFF, Q_MAX, Q_MAX));
    directed.push_back(make_obstacle(TO_VEHICLE, Q_MIN, Q_MIN, '0, Q_MIN, Q_MAX));
    directed.push_back(make_obstacle(TO_WORLD, Q_MIN, Q_MAX, 16'h8000, Q_MIN, Q_MIN));
    directed.push_back(make_obstacle(TO_VEHICLE, 32'sd1024, -32'sd2048, 16'h4000,
                                     -32'sd1, 32'sd1));
    foreach (directed[k]) send_obstacle(directed[k]);
    directed.delete();

    // Ego at the far corner and at an eighth turn: the offsets and the
    // 33-bit differences push many of the positions into saturation.
    set_ego(Q_MAX, Q_MIN, 16'h2000, 1'b0);
    directed.push_back(make_obstacle(TO_WORLD, Q_MAX, Q_MAX, 16'hFFFF, Q_MAX, Q_MAX));
    directed.push_back(make_obstacle(TO_VEHICLE, Q_MIN, Q_MAX, '0, Q_MIN, Q_MIN));
    directed.push_back(make_obstacle(TO_WORLD, Q_MIN, Q_MIN, 16'h1234, Q_MAX, Q_MIN));
    directed.push_back(make_obstacle(TO_VEHICLE, Q_MAX, Q_MIN, 16'hE000, Q_MIN, Q_MAX));
    directed.push_back(make_obstacle(TO_VEHICLE, 32'sd1, -32'sd1, 16'h0001, -32'sd1,
                                     32'sd1));
    foreach (directed[k]) send_obstacle(directed[k]);
    directed.delete();

    // The opposite corner with the largest heading, so the angle just misses
    // a quadrant boundary.
    set_ego(Q_MIN, Q_MAX, 16'hFFFF, 1'b0);
    directed.push_back(make_obstacle(TO_WORLD, Q_MIN, Q_MIN, 16'h0001, Q_MIN, Q_MIN));
    directed.push_back(make_obstacle(TO_VEHICLE, Q_MIN, Q_MAX, 16'hFFFF, Q_MAX, Q_MAX));
    directed.push_back(make_obstacle(TO_WORLD, '0, '0, '0, '0, '0));
    directed.push_back(make_obstacle(TO_VEHICLE, 32'sd5000, 32'sd7000, 16'h7FFF,
                                     -32'sd3000, 32'sd900));
    foreach (directed[k]) send_obstacle(directed[k]);
    directed.delete();

    // A quarter-turn heading makes the world-bound rotation the identity; the
    // write to the unused index that follows must not disturb it.
    set_ego(32'sd10240, -32'sd20480, pft_pkg::QUARTER_TURN, 1'b1);
    directed.push_back(make_obstacle(TO_WORLD, Q_MAX, Q_MIN, 16'h8000, Q_MAX, Q_MIN));
    directed.push_back(make_obstacle(TO_VEHICLE, Q_MAX, Q_MIN, 16'h4000, Q_MIN, Q_MAX));
    directed.push_back(make_obstacle(TO_WORLD, 32'sd100, 32'sd200, 16'h0000, 32'sd7,
                                     -32'sd7));
    directed.push_back(make_obstacle(TO_VEHICLE, -32'sd100, 32'sd300, 16'hC000, 32'sd0,
                                     32'sd50));
    foreach (directed[k]) send_obstacle(directed[k]);
    directed.delete();

    // Random phases, each under a fresh ego pose; some run without any idling.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_ego(rand_coord(), rand_coord(), rand_angle(), $urandom_range(0, 3) == 0);
      tx_calm = (ph == 1) || ($urandom_range(0, 4) == 0);
      rx_calm = (ph == 1) || ($urandom_range(0, 4) == 0);
      for (int n = 0; n < WORDS_PER_PHASE; n++) send_obstacle(rand_obstacle());
    end

    tx_calm = 1'b0;
    rx_calm = 1'b0;
    drain_pipe();
    if (board.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pft_pkg.sv
rtl/pft_in_if.sv
rtl/pft_out_if.sv
rtl/pft_cordic_cell.sv
rtl/pft_rot_lane.sv
rtl/pose_frame_transform_2d_top.sv
rtl/pft_checker.sv
tb/tb_pose_frame_transform_2d_top.sv
